>>> sv/sta_pkg.sv
// ----------------------------------------------------------------------------
// sta_pkg
// Shared types and constants of the slot table allocator.
// ----------------------------------------------------------------------------
package sta_pkg;

  localparam int IDX_BITS       = 10;
  localparam int OUT_VAL_BITS   = 32;
  localparam int SLOTS_DEF      = 1024;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_PICK    = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [IDX_BITS-1:0]     slot_index;
    logic [OUT_VAL_BITS-1:0] value;
  } sta_req_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]     result_index;
    logic [OUT_VAL_BITS-1:0] result_value;
    logic [1:0]              status;
  } sta_rsp_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } sta_state_e;

endpackage

>>> sv/sta_slot_mem.sv
// ----------------------------------------------------------------------------
// sta_slot_mem
// Slot value store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sta_slot_mem #(
  parameter int SLOTS      = 1024,
  parameter int VALUE_BITS = 32,
  localparam int IDX_W     = $clog2(SLOTS)
) (
  input  logic                  clk_i,
  input  logic                  re_i,
  input  logic [IDX_W-1:0]      raddr_i,
  output logic [VALUE_BITS-1:0] rdata_o,
  input  logic                  we_i,
  input  logic [IDX_W-1:0]      waddr_i,
  input  logic [VALUE_BITS-1:0] wdata_i
);

  logic [VALUE_BITS-1:0] mem [SLOTS];
  logic [VALUE_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/sta_free_stack.sv
// ----------------------------------------------------------------------------
// sta_free_stack
// LIFO of released slot indices held in a memory, with its top pointer.
// ----------------------------------------------------------------------------
module sta_free_stack
  import sta_pkg::*;
#(
  parameter int SLOTS  = 1024,
  localparam int IDX_W = $clog2(SLOTS),
  localparam int CNT_W = $clog2(SLOTS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stk_cmd_t         cmd_i,
  input  logic [IDX_W-1:0] push_idx_i,
  output logic [IDX_W-1:0] top_idx_o,
  output logic [CNT_W-1:0] top_o
);

  logic [IDX_W-1:0] mem [SLOTS];
  logic [IDX_W-1:0] rdata_q;
  logic [CNT_W-1:0] top_q, top_d;

  always_comb begin
    top_d = top_q;
    if (cmd_i.push) begin
      top_d = top_q + CNT_W'(1);
    end else if (cmd_i.pop) begin
      top_d = top_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
    end else begin
      top_q <= top_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[top_q[IDX_W-1:0]] <= push_idx_i;
    end
  end

  // entry below the top, meaningful only while the stack is not empty
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[IDX_W'(top_q - CNT_W'(1))];
  end

  assign top_idx_o = rdata_q;
  assign top_o     = top_q;

endmodule

>>> sv/slot_table_allocator_top.sv
// ----------------------------------------------------------------------------
// slot_table_allocator_top
// Indexed slot table with a fresh-index counter and a LIFO free list.
// ----------------------------------------------------------------------------
// result: res_valid_o is registered from the S_EXEC write-back state that
//   the accepting edge enters; the slot and free-list memories are read
//   ahead of the write-back cycle; no new command is taken until S_IDLE
// busy_o is high in the write-back cycle; results cannot be stalled
// reset clears the fresh counter and free-list pointer; memories are not cleared
module slot_table_allocator_top
  import sta_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  sta_req_t req_i,
  output logic     busy_o,
  output logic     res_valid_o,
  output sta_rsp_t res_o
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (CNT_W > IDX_BITS) ? CNT_W : IDX_BITS;

  sta_state_e state_q, state_d;
  sta_req_t   req_q;
  logic [CNT_W-1:0] issued_q, issued_d;
  logic       res_valid_q, res_valid_d;
  sta_rsp_t   res_q, res_d;

  logic                  accept;
  logic [VALUE_BITS-1:0] slot_rdata;
  logic                  slot_we;
  logic [IDX_W-1:0]      slot_waddr;
  logic [VALUE_BITS-1:0] slot_wdata;
  stk_cmd_t              stk_cmd;
  logic [IDX_W-1:0]      stk_top_idx;
  logic [CNT_W-1:0]      stk_top;
  logic [IDX_W-1:0]      req_idx;
  logic                  live;
  logic [IDX_W-1:0]      given;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q == S_EXEC);

  sta_slot_mem #(
    .SLOTS      (SLOTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .re_i    (accept),
    .raddr_i (IDX_W'(req_i.slot_index)),
    .rdata_o (slot_rdata),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata)
  );

  sta_free_stack #(
    .SLOTS (SLOTS)
  ) u_free_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (stk_cmd),
    .push_idx_i (req_idx),
    .top_idx_o  (stk_top_idx),
    .top_o      (stk_top)
  );

  assign req_idx = IDX_W'(req_q.slot_index);
  // an index is live once issued and while its slot holds a nonzero value
  assign live = (CMP_W'(req_q.slot_index) < CMP_W'(issued_q)) && (slot_rdata != '0);

  always_comb begin
    state_d     = state_q;
    issued_d    = issued_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    slot_we     = 1'b0;
    slot_waddr  = req_idx;
    slot_wdata  = '0;
    stk_cmd     = '0;
    given       = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d                = S_IDLE;
        res_valid_d            = 1'b1;
        res_d.result_index     = req_q.slot_index;
        res_d.result_value     = '0;
        res_d.status           = STAT_OK;
        case (req_q.opcode)
          OP_ADD: begin
            if (stk_top != '0) begin
              given       = stk_top_idx;
              stk_cmd.pop = 1'b1;
              slot_we     = 1'b1;
            end else if (issued_q < CNT_W'(SLOTS)) begin
              given    = IDX_W'(issued_q);
              issued_d = issued_q + CNT_W'(1);
              slot_we  = 1'b1;
            end
            slot_waddr = given;
            slot_wdata = VALUE_BITS'(req_q.value);
            if (slot_we) begin
              res_d.result_index = IDX_BITS'(given);
            end else begin
              res_d.result_index = '0;
              res_d.status       = STAT_FULL;
            end
          end
          OP_PICK: begin
            if (live) begin
              res_d.result_value = OUT_VAL_BITS'(slot_rdata);
            end else begin
              res_d.status = STAT_EMPTY;
            end
          end
          OP_RELEASE: begin
            if (live && (stk_top < CNT_W'(SLOTS))) begin
              slot_we      = 1'b1;
              stk_cmd.push = 1'b1;
            end else begin
              res_d.status = STAT_EMPTY;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef ASSERT_OFF
  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |=> res_valid_o)
    else $error("write-back cycle produced no result beat");

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(state_q == S_EXEC))
    else $error("result beat without a write-back cycle");

  a_free_le_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_top <= issued_q)
    else $error("free list holds more indices than were issued");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.status == STAT_FULL)) |->
      ($past(issued_q) == CNT_W'(SLOTS)) && ($past(stk_top) == '0))
    else $error("table full reported with indices still available");
`endif

endmodule
